// File: hw/rtl/itg_pkg.sv
// ---------------------------------------------------------------------------
// itg_pkg
// Types and constants shared by the icosphere triangle index generator.
// ---------------------------------------------------------------------------
package itg_pkg;

   localparam int NT_W        = 7;
   localparam int INDEX_W     = 16;
   localparam int FACE_W      = 5;
   localparam int NUM_FACES   = 20;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [INDEX_W-1:0] CORNER_COUNT = 16'd12;
   localparam logic [INDEX_W-1:0] EDGE_COUNT   = 16'd30;
   // edge point p of edge e sits at CORNER_COUNT + e*(nt-1) + p - 1
   localparam logic [INDEX_W-1:0] EDGE_OFFSET  = CORNER_COUNT - 16'd1;

   typedef enum logic [1:0] {
      VK_CORNER,
      VK_EDGE,
      VK_INTERIOR
   } vkind_type;

   // corner: id = corner number; edge: id = edge, pos = position;
   // interior: row and pos = local (r, c)
   typedef struct packed {
      vkind_type        kind;
      logic [4:0]       id;
      logic [NT_W-1:0]  pos;
      logic [NT_W-1:0]  row;
   } vdesc_type;

   typedef struct packed {
      logic              bad;
      logic [FACE_W-1:0] face;
      vdesc_type [2:0]   vert;
   } job_type;

   // subdivision register and values derived from it at write time
   typedef struct packed {
      logic [NT_W-1:0]    nt;
      logic [NT_W-1:0]    nt1;
      logic [12:0]        tri_size;
      logic [INDEX_W-1:0] int_base;
   } cfg_type;

endpackage

// File: hw/rtl/itg_req_if.sv
// ---------------------------------------------------------------------------
// itg_req_if
// Request channel: one triangle of one face.
// ---------------------------------------------------------------------------
interface itg_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] face;
   logic [5:0] row;
   logic [5:0] col;
   logic       reversed;

   modport source (output valid, output face, output row, output col, output reversed,
                   input ready);
   modport sink   (input valid, input face, input row, input col, input reversed,
                   output ready);
endinterface

// File: hw/rtl/itg_rsp_if.sv
// ---------------------------------------------------------------------------
// itg_rsp_if
// Response channel: three global vertex indices and an error flag.
// ---------------------------------------------------------------------------
interface itg_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] vertex_a;
   logic [15:0] vertex_b;
   logic [15:0] vertex_c;
   logic        bad_request;

   modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                   output bad_request, input ready);
   modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
                   input bad_request, output ready);
endinterface

// File: hw/rtl/icosphere_triangle_index_gen_unit.sv
// ---------------------------------------------------------------------------
// icosphere_triangle_index_gen_unit
// Maps one triangle of a subdivided icosahedron face to three global
// vertex indices.
//
//   channel   dir   handshake       payload
//   req_ch    in    valid/ready     face, row, col, reversed
//   rsp_ch    out   valid/ready     vertex_a, vertex_b, vertex_c, bad_request
//   csr_*     in    write enable    subdivisions (7 bits)
//
// One request per cycle sustained while the queue is not full; each request is
// written into a queue slot on the transfer edge, then passes the product
// stage and the sum stage into the response register.
// Front end classifies into a four-entry queue; req_ch.ready drops only when
// the queue is full, so the front keeps taking work while rsp_ch is stalled.
// Synchronous reset sets subdivisions to 1 and empties queue and pipeline.
// ---------------------------------------------------------------------------
module icosphere_triangle_index_gen_unit #(
   parameter int MAX_SUBDIV = 64
) (
   input  logic       clock,
   input  logic       reset,
   itg_req_if.sink    req_ch,
   itg_rsp_if.source  rsp_ch,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data
);

   itg_pkg::cfg_type cfg_ff, cfg_in;
   logic [13:0]      tri_prod;

   logic             push, pop, queue_full, head_valid;
   itg_pkg::job_type push_job, head_job;

   // derived values are computed from the written data so they are ready at once
   always_comb begin
      cfg_in.nt       = csr_write_data;
      cfg_in.nt1      = csr_write_data - 7'd1;
      tri_prod        = 14'(cfg_in.nt1) * 14'(csr_write_data - 7'd2);
      cfg_in.tri_size = tri_prod[13:1];
      cfg_in.int_base = itg_pkg::CORNER_COUNT
                      + 16'(itg_pkg::EDGE_COUNT * 16'(cfg_in.nt1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nt       <= 7'd1;
         cfg_ff.nt1      <= '0;
         cfg_ff.tri_size <= '0;
         cfg_ff.int_base <= itg_pkg::CORNER_COUNT;
      end else if (csr_write_enable) begin
         cfg_ff <= cfg_in;
      end
   end

   itg_front #(
      .MAX_SUBDIV (MAX_SUBDIV)
   ) u_front (
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   itg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   itg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: hw/rtl/itg_front.sv
// ---------------------------------------------------------------------------
// itg_front
// Accepts requests, checks them and classifies each vertex as corner,
// edge point or interior point of the face.
// ---------------------------------------------------------------------------
module itg_front #(
   parameter int MAX_SUBDIV = 64
) (
   itg_req_if.sink          req_ch,
   input  itg_pkg::cfg_type cfg,
   input  logic             queue_full,
   output logic             push,
   output itg_pkg::job_type job
);

   localparam logic [3:0] FACE_CORNER [itg_pkg::NUM_FACES][3] = '{
      '{4'd0, 4'd1, 4'd2},  '{4'd0, 4'd2, 4'd3},  '{4'd0, 4'd3, 4'd4},
      '{4'd0, 4'd4, 4'd5},  '{4'd0, 4'd5, 4'd1},  '{4'd1, 4'd6, 4'd2},
      '{4'd2, 4'd6, 4'd7},  '{4'd2, 4'd7, 4'd3},  '{4'd3, 4'd7, 4'd8},
      '{4'd3, 4'd8, 4'd4},  '{4'd4, 4'd8, 4'd9},  '{4'd4, 4'd9, 4'd5},
      '{4'd5, 4'd9, 4'd10}, '{4'd5, 4'd10, 4'd1}, '{4'd1, 4'd10, 4'd6},
      '{4'd11, 4'd7, 4'd6}, '{4'd11, 4'd8, 4'd7}, '{4'd11, 4'd9, 4'd8},
      '{4'd11, 4'd10, 4'd9}, '{4'd11, 4'd6, 4'd10}
   };

   localparam logic [4:0] FACE_EDGE [itg_pkg::NUM_FACES][3] = '{
      '{5'd0, 5'd5, 5'd1},    '{5'd1, 5'd6, 5'd2},    '{5'd2, 5'd7, 5'd3},
      '{5'd3, 5'd8, 5'd4},    '{5'd4, 5'd9, 5'd0},    '{5'd10, 5'd11, 5'd5},
      '{5'd11, 5'd20, 5'd12}, '{5'd12, 5'd13, 5'd6},  '{5'd13, 5'd21, 5'd14},
      '{5'd14, 5'd15, 5'd7},  '{5'd15, 5'd22, 5'd16}, '{5'd16, 5'd17, 5'd8},
      '{5'd17, 5'd23, 5'd18}, '{5'd18, 5'd19, 5'd9},  '{5'd19, 5'd24, 5'd10},
      '{5'd26, 5'd20, 5'd25}, '{5'd27, 5'd21, 5'd26}, '{5'd28, 5'd22, 5'd27},
      '{5'd29, 5'd23, 5'd28}, '{5'd25, 5'd24, 5'd29}
   };

   // left, bottom, right side direction flags
   localparam logic FACE_DIR [itg_pkg::NUM_FACES][3] = '{
      '{1'b1, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0},
      '{1'b1, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0},
      '{1'b0, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b0},
      '{1'b1, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0},
      '{1'b0, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b0},
      '{1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1}
   };

   function automatic itg_pkg::vdesc_type classify(
      input logic [itg_pkg::NT_W-1:0]   nt,
      input logic [itg_pkg::FACE_W-1:0] f,
      input logic [itg_pkg::NT_W-1:0]   r,
      input logic [itg_pkg::NT_W-1:0]   c
   );
      itg_pkg::vdesc_type d;
      d = '{kind: itg_pkg::VK_CORNER, id: '0, pos: '0, row: '0};
      priority if (r == '0) begin
         d.id = {1'b0, FACE_CORNER[f][0]};
      end else if (r == nt) begin
         priority if (c == '0) begin
            d.id = {1'b0, FACE_CORNER[f][1]};
         end else if (c == nt) begin
            d.id = {1'b0, FACE_CORNER[f][2]};
         end else begin
            d.kind = itg_pkg::VK_EDGE;
            d.id   = FACE_EDGE[f][1];
            d.pos  = FACE_DIR[f][1] ? c : nt - c;
         end
      end else if (c == '0) begin
         d.kind = itg_pkg::VK_EDGE;
         d.id   = FACE_EDGE[f][0];
         d.pos  = FACE_DIR[f][0] ? r : nt - r;
      end else if (c == r) begin
         d.kind = itg_pkg::VK_EDGE;
         d.id   = FACE_EDGE[f][2];
         d.pos  = FACE_DIR[f][2] ? nt - r : r;
      end else begin
         d.kind = itg_pkg::VK_INTERIOR;
         d.row  = r;
         d.pos  = c;
      end
      return d;
   endfunction

   logic [itg_pkg::NT_W-1:0]   r0, r1, c0, c1;
   logic [itg_pkg::FACE_W-1:0] face_safe;
   logic                       bad;

   always_comb begin
      r0 = {1'b0, req_ch.row};
      c0 = {1'b0, req_ch.col};
      r1 = r0 + 7'd1;
      c1 = c0 + 7'd1;

      bad = (cfg.nt == '0)
         || ({1'b0, cfg.nt} > 8'(MAX_SUBDIV))
         || (req_ch.face > 5'(itg_pkg::NUM_FACES - 1))
         || (r0 >= cfg.nt)
         || (req_ch.reversed ? (c0 >= r0) : (c0 > r0));

      face_safe = bad ? '0 : req_ch.face;

      job.bad  = bad;
      job.face = face_safe;
      if (bad) begin
         job.vert = '0;
      end else begin
         job.vert[0] = classify(cfg.nt, face_safe, r0, c0);
         if (req_ch.reversed) begin
            job.vert[1] = classify(cfg.nt, face_safe, r1, c1);
            job.vert[2] = classify(cfg.nt, face_safe, r0, c1);
         end else begin
            job.vert[1] = classify(cfg.nt, face_safe, r1, c0);
            job.vert[2] = classify(cfg.nt, face_safe, r1, c1);
         end
      end
   end

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

endmodule

// File: hw/rtl/itg_queue.sv
// ---------------------------------------------------------------------------
// itg_queue
// Small FIFO of classified jobs between the front and back ends.
// ---------------------------------------------------------------------------
module itg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  itg_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output itg_pkg::job_type head_job
);

   localparam int PTR_W = $clog2(itg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(itg_pkg::QUEUE_DEPTH + 1);

   itg_pkg::job_type  slot_ff [itg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full       = (count_ff == CNT_W'(itg_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(itg_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("pop from empty queue");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(itg_pkg::QUEUE_DEPTH))
         |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

// File: hw/rtl/itg_back.sv
// ---------------------------------------------------------------------------
// itg_back
// Two-stage index pipeline: products, then sums into the response register.
// ---------------------------------------------------------------------------
module itg_back (
   input  logic             clock,
   input  logic             reset,
   input  itg_pkg::cfg_type cfg,
   input  logic             head_valid,
   input  itg_pkg::job_type head_job,
   output logic             pop,
   itg_rsp_if.source        rsp_ch
);

   logic                    out_adv, s1_ready;
   logic [13:0]             prod [3];
   logic [17:0]             ftri_full;

   logic                    s1_valid_ff;
   itg_pkg::job_type        s1_job_ff;
   logic [13:0]             s1_prod_ff [3];
   logic [itg_pkg::INDEX_W-1:0] s1_ftri_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_bad_ff;
   logic [itg_pkg::INDEX_W-1:0] idx_in [3];
   logic [itg_pkg::INDEX_W-1:0] idx_ff [3];

   always_comb begin
      out_adv  = !rsp_valid_ff || rsp_ch.ready;
      s1_ready = !s1_valid_ff || out_adv;
      pop      = head_valid && s1_ready;
   end

   // stage 1: one product per vertex lane, plus the face offset shared by all
   always_comb begin
      logic [6:0] opa, opb;
      for (int k = 0; k < 3; k++) begin
         if (head_job.vert[k].kind == itg_pkg::VK_EDGE) begin
            opa = {2'b00, head_job.vert[k].id};
            opb = cfg.nt1;
         end else begin
            opa = head_job.vert[k].row - 7'd1;
            opb = head_job.vert[k].row - 7'd2;
         end
         prod[k] = 14'(opa) * 14'(opb);
      end
      ftri_full = 18'(head_job.face) * 18'(cfg.tri_size);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= head_valid;
      end
      if (s1_ready) begin
         s1_job_ff  <= head_job;
         s1_prod_ff <= prod;
         s1_ftri_ff <= ftri_full[itg_pkg::INDEX_W-1:0];
      end
   end

   // stage 2: add up the index of each vertex
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         unique case (s1_job_ff.vert[k].kind)
            itg_pkg::VK_CORNER: begin
               idx_in[k] = 16'(s1_job_ff.vert[k].id);
            end
            itg_pkg::VK_EDGE: begin
               idx_in[k] = 16'(s1_prod_ff[k]) + 16'(s1_job_ff.vert[k].pos)
                         + itg_pkg::EDGE_OFFSET;
            end
            itg_pkg::VK_INTERIOR: begin
               idx_in[k] = cfg.int_base + s1_ftri_ff + 16'(s1_prod_ff[k][13:1])
                         + 16'(s1_job_ff.vert[k].pos) - 16'd1;
            end
            default: begin
               idx_in[k] = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (out_adv) begin
         rsp_bad_ff <= s1_job_ff.bad;
         idx_ff     <= idx_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.vertex_a    = idx_ff[0];
   assign rsp_ch.vertex_b    = idx_ff[1];
   assign rsp_ch.vertex_c    = idx_ff[2];
   assign rsp_ch.bad_request = rsp_bad_ff;

`ifndef SYNTHESIS
   a_stall_holds_s1: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_adv) |=> (s1_valid_ff && $stable(s1_job_ff)))
      else $error("stage 1 lost its job during a stall");

   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_adv) |-> !pop)
      else $error("pop while stage 1 is blocked");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (idx_ff[0] == '0 && idx_ff[1] == '0
                                        && idx_ff[2] == '0))
      else $error("rejected request with non-zero index");
`endif

endmodule

// File: bench/icosphere_triangle_index_gen_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// icosphere_triangle_index_gen_unit_tb
// Self-checking bench for the icosphere triangle index generator. A short
// table of directed requests is followed by random phases, each under its
// own subdivision setting. Every request transfer queues the predicted
// vertex triple; every response transfer is checked against the oldest one.
// Both channels idle at random, with occasional stretches at full rate.
// ---------------------------------------------------------------------------
module icosphere_triangle_index_gen_unit_tb;

   localparam int MAX_SUBDIV    = 64;
   localparam int PHASE_COUNT   = 11;
   localparam int PHASE_ITEMS   = 100;
   localparam int DIRECTED_ROWS = 23;

   typedef struct packed {
      logic [15:0] vertex_a;
      logic [15:0] vertex_b;
      logic [15:0] vertex_c;
      logic        bad;
   } triangle_type;

   typedef struct packed {
      logic [6:0]   nt;
      logic [4:0]   face;
      logic [5:0]   row;
      logic [5:0]   col;
      logic         rev;
      logic         known;
      triangle_type want;
   } directed_row_type;

   localparam triangle_type REJECTED = '{16'd0, 16'd0, 16'd0, 1'b1};
   localparam triangle_type NO_VALUE = '{16'd0, 16'd0, 16'd0, 1'b0};

   // corners, shared edges and edge directions (left, bottom, right) per face
   localparam int FACE_CORNER [20][3] = '{
      '{0,1,2}, '{0,2,3}, '{0,3,4}, '{0,4,5}, '{0,5,1},
      '{1,6,2}, '{2,6,7}, '{2,7,3}, '{3,7,8}, '{3,8,4},
      '{4,8,9}, '{4,9,5}, '{5,9,10}, '{5,10,1}, '{1,10,6},
      '{11,7,6}, '{11,8,7}, '{11,9,8}, '{11,10,9}, '{11,6,10}};
   localparam int FACE_EDGE [20][3] = '{
      '{0,5,1}, '{1,6,2}, '{2,7,3}, '{3,8,4}, '{4,9,0},
      '{10,11,5}, '{11,20,12}, '{12,13,6}, '{13,21,14}, '{14,15,7},
      '{15,22,16}, '{16,17,8}, '{17,23,18}, '{18,19,9}, '{19,24,10},
      '{26,20,25}, '{27,21,26}, '{28,22,27}, '{29,23,28}, '{25,24,29}};
   localparam int FACE_DIR [20][3] = '{
      '{1,1,0}, '{1,1,0}, '{1,1,0}, '{1,1,0}, '{1,1,0},
      '{1,1,0}, '{0,1,0}, '{1,1,0}, '{0,1,0}, '{1,1,0},
      '{0,1,0}, '{1,1,0}, '{0,1,0}, '{1,1,0}, '{0,1,0},
      '{0,0,1}, '{0,0,1}, '{0,0,1}, '{0,0,1}, '{0,0,1}};

   // expected value typed in only where it is plain from the corners
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{7'd1,   5'd0,  6'd0,  6'd0,  1'b0, 1'b1, '{16'd0, 16'd1, 16'd2, 1'b0}},
      '{7'd1,   5'd19, 6'd0,  6'd0,  1'b0, 1'b1, '{16'd11, 16'd6, 16'd10, 1'b0}},
      '{7'd1,   5'd6,  6'd0,  6'd0,  1'b0, 1'b1, '{16'd2, 16'd6, 16'd7, 1'b0}},
      '{7'd1,   5'd0,  6'd0,  6'd0,  1'b1, 1'b1, REJECTED},   // downward in row 0
      '{7'd1,   5'd0,  6'd1,  6'd0,  1'b0, 1'b1, REJECTED},
      '{7'd1,   5'd20, 6'd0,  6'd0,  1'b0, 1'b1, REJECTED},
      '{7'd1,   5'd31, 6'd0,  6'd0,  1'b0, 1'b1, REJECTED},
      '{7'd1,   5'd0,  6'd0,  6'd1,  1'b0, 1'b1, REJECTED},
      '{7'd64,  5'd0,  6'd0,  6'd0,  1'b0, 1'b0, NO_VALUE},
      '{7'd64,  5'd19, 6'd63, 6'd63, 1'b0, 1'b0, NO_VALUE},
      '{7'd64,  5'd19, 6'd63, 6'd62, 1'b1, 1'b0, NO_VALUE},
      '{7'd64,  5'd13, 6'd63, 6'd0,  1'b0, 1'b0, NO_VALUE},
      '{7'd64,  5'd5,  6'd32, 6'd16, 1'b1, 1'b0, NO_VALUE},
      '{7'd64,  5'd0,  6'd63, 6'd63, 1'b1, 1'b1, REJECTED},
      '{7'd64,  5'd10, 6'd63, 6'd31, 1'b0, 1'b0, NO_VALUE},
      '{7'd0,   5'd0,  6'd0,  6'd0,  1'b0, 1'b1, REJECTED},   // setting below range
      '{7'd127, 5'd0,  6'd0,  6'd0,  1'b0, 1'b1, REJECTED},   // setting above range
      '{7'd2,   5'd6,  6'd1,  6'd0,  1'b1, 1'b0, NO_VALUE},
      '{7'd2,   5'd15, 6'd1,  6'd1,  1'b0, 1'b0, NO_VALUE},
      '{7'd3,   5'd8,  6'd2,  6'd1,  1'b0, 1'b0, NO_VALUE},
      '{7'd3,   5'd17, 6'd2,  6'd1,  1'b1, 1'b0, NO_VALUE},
      '{7'd3,   5'd12, 6'd1,  6'd0,  1'b0, 1'b0, NO_VALUE},
      '{7'd65,  5'd0,  6'd0,  6'd0,  1'b0, 1'b1, REJECTED}};

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [6:0] csr_write_data;

   itg_req_if req_ch ();
   itg_rsp_if rsp_ch ();

   icosphere_triangle_index_gen_unit #(
      .MAX_SUBDIV (MAX_SUBDIV)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   triangle_type expected_triangles [$];
   logic [6:0]   subdiv_setting;
   int unsigned  error_count;
   bit           sender_burst;
   bit           receiver_burst;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400us;
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned point_id(input int unsigned nt, input int unsigned f,
                                            input int unsigned r, input int unsigned c);
      int unsigned pos;
      if (r == 0) return FACE_CORNER[f][0];
      if (r == nt) begin
         if (c == 0) return FACE_CORNER[f][1];
         if (c == nt) return FACE_CORNER[f][2];
         pos = (FACE_DIR[f][1] != 0) ? c : nt - c;
         return 12 + FACE_EDGE[f][1] * (nt - 1) + pos - 1;
      end
      if (c == 0) begin
         pos = (FACE_DIR[f][0] != 0) ? r : nt - r;
         return 12 + FACE_EDGE[f][0] * (nt - 1) + pos - 1;
      end
      if (c == r) begin
         // right side runs apex to third corner, so the flag sense is inverted
         pos = (FACE_DIR[f][2] != 0) ? nt - r : r;
         return 12 + FACE_EDGE[f][2] * (nt - 1) + pos - 1;
      end
      return 12 + 30 * (nt - 1) + f * ((nt - 1) * (nt - 2) / 2)
             + (r - 1) * (r - 2) / 2 + c - 1;
   endfunction

   function automatic triangle_type predict_triangle(input logic [4:0] face,
                                                     input logic [5:0] row,
                                                     input logic [5:0] col,
                                                     input logic rev);
      triangle_type t;
      int unsigned  nt;
      int unsigned  f;
      int unsigned  r;
      int unsigned  c;
      t  = NO_VALUE;
      nt = subdiv_setting;
      f  = face;
      r  = row;
      c  = col;
      if (nt == 0 || nt > MAX_SUBDIV || f >= itg_pkg::NUM_FACES || r >= nt ||
          (rev ? (c >= r) : (c > r))) begin
         t = REJECTED;
      end else begin
         t.vertex_a = 16'(point_id(nt, f, r, c));
         if (rev) begin
            t.vertex_b = 16'(point_id(nt, f, r + 1, c + 1));
            t.vertex_c = 16'(point_id(nt, f, r, c + 1));
         end else begin
            t.vertex_b = 16'(point_id(nt, f, r + 1, c));
            t.vertex_c = 16'(point_id(nt, f, r + 1, c + 1));
         end
      end
      return t;
   endfunction

   task automatic send_triangle(input logic [4:0] face, input logic [5:0] row,
                                input logic [5:0] col, input logic rev,
                                input logic known, input triangle_type want);
      int unsigned  gap;
      triangle_type entry;
      if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.face     <= face;
      req_ch.row      <= row;
      req_ch.col      <= col;
      req_ch.reversed <= rev;
      do @(posedge clock); while (!req_ch.ready);
      entry = known ? want : predict_triangle(face, row, col, rev);
      expected_triangles.insert(expected_triangles.size(), entry);
   endtask

   // hold off requests until every outstanding response has come back
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (expected_triangles.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_subdivisions(input logic [6:0] value);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      subdiv_setting = value;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // response side: insert random stalls before each transfer
   initial begin
      int unsigned stall;
      forever begin
         if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
         stall = receiver_burst ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && !reset));
      end
   end

   always @(posedge clock) begin
      triangle_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_triangles.size() == 0) begin
            $display("%0t: response transfer with nothing outstanding", $time);
            error_count++;
         end else begin
            want = expected_triangles.pop_front();
            check_field("vertex_a", want.vertex_a, rsp_ch.vertex_a);
            check_field("vertex_b", want.vertex_b, rsp_ch.vertex_b);
            check_field("vertex_c", want.vertex_c, rsp_ch.vertex_c);
            check_field("bad_request", 16'(want.bad), 16'(rsp_ch.bad_request));
         end
      end
   end

   initial begin
      logic [6:0]  nt;
      logic [4:0]  face;
      logic [5:0]  row;
      logic [5:0]  col;
      logic        rev;
      int unsigned pick;

      error_count      = 0;
      subdiv_setting   = 7'd1;
      sender_burst     = 1'b0;
      receiver_burst   = 1'b0;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 7'd0;
      req_ch.valid     <= 1'b0;
      req_ch.face      <= '0;
      req_ch.row       <= '0;
      req_ch.col       <= '0;
      req_ch.reversed  <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].nt != subdiv_setting) set_subdivisions(directed_rows[i].nt);
         send_triangle(directed_rows[i].face, directed_rows[i].row, directed_rows[i].col,
                       directed_rows[i].rev, directed_rows[i].known, directed_rows[i].want);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         unique case (phase)
            0: nt = 7'd64;
            1: nt = 7'd1;
            2: nt = 7'd2;
            default: begin
               pick = $urandom_range(0, 9);
               if (pick == 0) nt = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
               else nt = 7'($urandom_range(1, MAX_SUBDIV));
            end
         endcase
         set_subdivisions(nt);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) drain_responses();
            if (nt >= 1 && nt <= MAX_SUBDIV && $urandom_range(0, 4) != 0) begin
               // well-formed triangle, biased towards the grid borders
               face = 5'($urandom_range(0, itg_pkg::NUM_FACES - 1));
               rev  = (nt >= 2) ? 1'($urandom_range(0, 1)) : 1'b0;
               if ($urandom_range(0, 3) == 0) row = 6'(nt - 1);
               else row = 6'($urandom_range(rev ? 1 : 0, nt - 1));
               pick = $urandom_range(0, 5);
               if (pick == 0) col = 6'd0;
               else if (pick == 1) col = rev ? row - 6'd1 : row;
               else col = 6'($urandom_range(0, rev ? row - 1 : row));
            end else begin
               face = 5'($urandom_range(0, 31));
               row  = 6'($urandom_range(0, 63));
               col  = 6'($urandom_range(0, 63));
               rev  = 1'($urandom_range(0, 1));
            end
            send_triangle(face, row, col, rev, 1'b0, NO_VALUE);
         end
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
